/* rtl/psg_tone_noise_envelope_synth_defines.svh */
// Assertion macros shared by the sound generator RTL.
`ifndef PSG_TONE_NOISE_ENVELOPE_SYNTH_DEFINES_SVH
`define PSG_TONE_NOISE_ENVELOPE_SYNTH_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/psg_pkg.sv */
//------------------------------------------------------------------------------
// psg_pkg
// Shared constants and types for the programmable sound generator bank.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

  localparam int MaxChipsDefault = 3;

  // Configuration register indexes.
  localparam logic [1:0] CfgChips = 2'd0;
  localparam logic [1:0] CfgInc   = 2'd1;
  localparam logic [1:0] CfgGain  = 2'd2;
  localparam logic [1:0] CfgDiv   = 2'd3;

  // Input operation codes.
  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Register numbers with side effects or special meaning.
  localparam logic [3:0] RegNoise = 4'd6;
  localparam logic [3:0] RegMixer = 4'd7;
  localparam logic [3:0] RegEnvLo = 4'd11;
  localparam logic [3:0] RegEnvHi = 4'd12;
  localparam logic [3:0] RegShape = 4'd13;

  typedef struct packed {
    logic       op;
    logic [1:0] chip;
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
  } psg_in_t;

  typedef struct packed {
    logic [15:0] sample;
  } psg_out_t;

endpackage

/* rtl/psg_if.sv */
//------------------------------------------------------------------------------
// psg_if
// Valid/ready channel carrying one payload beat.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psg_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/psg_tone_noise_envelope_synth.sv */
//------------------------------------------------------------------------------
// psg_tone_noise_envelope_synth
// Bank of AY-3-8910 style sound chips: register writes and sample ticks in,
// mixed 16-bit samples out.
//------------------------------------------------------------------------------
// Channel    Dir  Payload                          Beat
// in_ch      in   op, chip, reg_addr, reg_data     one write or one tick
// out_ch     out  sample (signed 16)               one per tick
// cfg        in   cfg_we, cfg_index, cfg_data      one register write
//
// A write beat is accepted in S_IDLE and in_ch stays ready after it.
// A tick steps through each chip in use (fetch of the chip's registers through
// the single read port, noise, two envelope steps, three channels), then
// runs the bit-serial divider and waits in S_OUT until out_ch takes the sample.
// After reset a clearing pass zeroes all 16*MAX_CHIPS entries of the register
// memory while in_ch is held not ready.
// in_ch stalls while a beat is in work or the result waits in out_ch.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_tone_noise_envelope_synth
  import psg_pkg::*;
#(
  parameter int MAX_CHIPS = MaxChipsDefault
) (
  input  logic       clk,
  input  logic       rst,
  psg_if.sink        in_ch,
  psg_if.source      out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

`include "psg_tone_noise_envelope_synth_defines.svh"

  localparam int CW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int AW = CW + 4;
  localparam int Depth = MAX_CHIPS * 16;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_NOISE = 9'b000001000,
    S_ENV   = 9'b000010000,
    S_ENVB  = 9'b000100000,
    S_CHAN  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0] chips_in_use;
  logic [3:0] tick_increment;
  logic [3:0] channel_gain;
  logic [7:0] output_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      chips_in_use   <= 2'd1;
      tick_increment <= 4'd9;
      channel_gain   <= 4'd11;
      output_divisor <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgChips: chips_in_use   <= cfg_data[1:0];
        CfgInc:   tick_increment <= cfg_data[3:0];
        CfgGain:  channel_gain   <= cfg_data[3:0];
        CfgDiv:   output_divisor <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Sound register memory, one write and one registered read per cycle.
  logic [7:0]    regs [Depth];
  logic [7:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] clr_addr;

  // Per-chip state, kept in flip-flops; each entry is read by the chip index.
  logic [12:0] pcnt [MAX_CHIPS][4];
  logic        tneg [MAX_CHIPS][3];
  logic [16:0] lfsr [MAX_CHIPS];
  logic [20:0] ecnt [MAX_CHIPS];
  logic [4:0]  estep [MAX_CHIPS];
  logic        erise [MAX_CHIPS];
  logic        ehold [MAX_CHIPS];
  logic [3:0]  eshape [MAX_CHIPS];
  logic        lvalid [MAX_CHIPS];
  logic [3:0]  latch [MAX_CHIPS];
  logic [3:0]  elevel [MAX_CHIPS];

  // Copy of the current chip's registers 0 to 12.
  logic [7:0]  rc [13];
  logic [3:0]  fidx;

  logic [CW-1:0] k;
  logic [1:0]  c;
  logic [15:0] acc;
  logic [1:0]  nchips;

  // Divider state.
  logic        neg;
  logic [15:0] quo;
  logic [8:0]  rem;
  logic [4:0]  dcnt;
  logic [7:0]  dvs;
  logic [15:0] sample_q;

  // Current chip's derived fields.
  logic [7:0]  r6, r7, r11, r12, vreg;
  logic [11:0] tper;
  logic [20:0] efull;
  logic [15:0] eper;
  logic [1:0]  en;
  logic [3:0]  vol;
  logic [7:0]  amount;
  logic        high;
  logic [12:0] csum;

  // Memory port control: clearing pass after reset, else accepted writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'd0;
    mem_raddr = {k, fidx};
    if (state == S_CLR) begin
      mem_we = 1'b1;
    end else if (state == S_IDLE && in_ch.valid && in_ch.data.op == OpWrite &&
                 32'(in_ch.data.chip) < MAX_CHIPS) begin
      mem_we    = 1'b1;
      mem_waddr = {CW'(in_ch.data.chip), in_ch.data.reg_addr};
      mem_wdata = in_ch.data.reg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) regs[mem_waddr] <= mem_wdata;
    rd_q <= regs[mem_raddr];
  end

  always_comb begin
    r6   = rc[RegNoise];
    r7   = rc[RegMixer];
    r11  = rc[RegEnvLo];
    r12  = rc[RegEnvHi];
    tper = {rc[{1'b0, c, 1'b1}][3:0], rc[{1'b0, c, 1'b0}]};
    vreg = rc[4'd8 + {2'b00, c}];
    eper = {r12, r11};
    efull = (eper == 16'd0) ? 21'd16 : {1'b0, eper, 4'b0000};
    en   = {~r7[3 + c], ~r7[c]};
    vol  = vreg[4] ? elevel[k] : vreg[3:0];
    amount = {4'd0, channel_gain} * {4'd0, vol};
    high = !((en[0] && tneg[k][c]) || (en[1] && !lfsr[k][0]));
    // Shared 13-bit period adder.
    csum = pcnt[k][(state == S_NOISE) ? 2'd3 : c] + {9'd0, tick_increment};
  end

  logic [20:0] esum;
  assign esum = ecnt[k] + {17'd0, tick_increment};

  logic [8:0] rtry;
  assign rtry = {rem[7:0], quo[15]};

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.sample = sample_q;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      for (int i = 0; i < MAX_CHIPS; i++) begin
        for (int j = 0; j < 4; j++) pcnt[i][j] <= 13'd0;
        for (int j = 0; j < 3; j++) tneg[i][j] <= 1'b0;
        lfsr[i] <= 17'd1; ecnt[i] <= 21'd0; estep[i] <= 5'd0;
        erise[i] <= 1'b0; ehold[i] <= 1'b0; eshape[i] <= 4'd0;
        lvalid[i] <= 1'b0; latch[i] <= 4'd0; elevel[i] <= 4'd0;
      end
      k <= '0; c <= 2'd0; acc <= 16'd0; nchips <= 2'd0; fidx <= 4'd0;
      neg <= 1'b0; quo <= 16'd0; rem <= 9'd0; dcnt <= 5'd0; dvs <= 8'd1;
    end else begin
      unique case (state)
        S_CLR: begin
          if (32'(clr_addr) == Depth - 1) state <= S_IDLE;
          else clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.op == OpWrite) begin
              if (32'(in_ch.data.chip) < MAX_CHIPS) begin
                if (in_ch.data.reg_addr == RegShape &&
                    (!lvalid[CW'(in_ch.data.chip)] ||
                     latch[CW'(in_ch.data.chip)] != in_ch.data.reg_data[3:0])) begin
                  lvalid[CW'(in_ch.data.chip)] <= 1'b1;
                  latch[CW'(in_ch.data.chip)]  <= in_ch.data.reg_data[3:0];
                  eshape[CW'(in_ch.data.chip)] <= in_ch.data.reg_data[3:0];
                  estep[CW'(in_ch.data.chip)]  <= 5'd0;
                  ecnt[CW'(in_ch.data.chip)]   <= 21'd0;
                  ehold[CW'(in_ch.data.chip)]  <= 1'b0;
                  erise[CW'(in_ch.data.chip)]  <= in_ch.data.reg_data[2];
                end
              end
            end else begin
              k <= '0; c <= 2'd0; acc <= 16'd0; fidx <= 4'd0;
              nchips <= (32'(chips_in_use) > MAX_CHIPS) ? 2'(MAX_CHIPS) : chips_in_use;
              dvs <= (output_divisor == 8'd0) ? 8'd1 : output_divisor;
              state <= (chips_in_use == 2'd0) ? S_DIV : S_FETCH;
              dcnt <= 5'd0;
              quo <= 16'd0; rem <= 9'd0; neg <= 1'b0;
            end
          end
        end
        S_FETCH: begin
          // Read data is registered and belongs to the previous address.
          if (fidx != 4'd0) rc[fidx - 4'd1] <= rd_q;
          if (fidx == 4'd13) state <= S_NOISE;
          else fidx <= fidx + 4'd1;
        end
        S_NOISE: begin
          if (r6[4:0] != 5'd0) begin
            if (csum > {8'd0, r6[4:0]}) begin
              pcnt[k][3] <= csum - {8'd0, r6[4:0]};
              lfsr[k] <= {lfsr[k][0] ^ lfsr[k][3], lfsr[k][16:1]};
            end else pcnt[k][3] <= csum;
          end
          state <= S_ENV;
        end
        S_ENV: begin
          // Counter advance and step update.
          if (!ehold[k]) begin
            if (esum >= efull) begin
              ecnt[k] <= esum - efull;
              if (estep[k] == 5'd15) begin
                if (!eshape[k][3]) begin
                  estep[k] <= 5'd0; ehold[k] <= 1'b1; erise[k] <= 1'b0;
                end else if (eshape[k][0]) begin
                  estep[k] <= 5'd15; ehold[k] <= 1'b1;
                  if (eshape[k][1]) erise[k] <= !erise[k];
                end else begin
                  estep[k] <= 5'd0;
                  if (eshape[k][1]) erise[k] <= !erise[k];
                end
              end else estep[k] <= estep[k] + 5'd1;
            end else ecnt[k] <= esum;
          end
          state <= S_ENVB;
        end
        S_ENVB: begin
          if (ehold[k] && !eshape[k][3]) elevel[k] <= 4'd0;
          else elevel[k] <= erise[k] ? estep[k][3:0] : 4'd15 - estep[k][3:0];
          c <= 2'd0;
          state <= S_CHAN;
        end
        S_CHAN: begin
          if (tper != 12'd0 && vol != 4'd0 && en != 2'b00) begin
            acc <= high ? acc + {8'd0, amount} : acc - {8'd0, amount};
            if (csum > {1'b0, tper}) begin
              pcnt[k][c] <= csum - {1'b0, tper};
              tneg[k][c] <= !tneg[k][c];
            end else pcnt[k][c] <= csum;
          end
          if (c == 2'd2) begin
            if (32'(k) + 1 >= 32'(nchips)) state <= S_DIV;
            else begin
              k <= k + CW'(1);
              fidx <= 4'd0;
              state <= S_FETCH;
            end
          end else c <= c + 2'd1;
        end
        S_DIV: begin
          // The first step loads the magnitude, then one quotient bit per cycle.
          if (dcnt == 5'd0) begin
            neg <= acc[9];
            quo <= acc[9] ? 16'd0 - {acc[9:0], 6'd0} : {acc[9:0], 6'd0};
            rem <= 9'd0;
            dcnt <= 5'd1;
          end else if (dcnt == 5'd17) begin
            sample_q <= neg ? 16'd0 - quo : quo;
            state <= S_OUT;
          end else begin
            if (rtry >= {1'b0, dvs}) begin
              rem <= rtry - {1'b0, dvs};
              quo <= {quo[14:0], 1'b1};
            end else begin
              rem <= rtry;
              quo <= {quo[14:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSG_ASSERT_IMPL(a_out_only_in_out, out_ch.valid, !in_ch.ready, "output and input open together")
  `PSG_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(sample_q), "result dropped")
  `PSG_ASSERT_IMPL(a_chan_range, state == S_CHAN, c != 2'd3, "channel index out of range")
  `PSG_ASSERT_IMPL(a_div_nonzero, state == S_DIV, dvs != 8'd0, "divisor zero")
  `PSG_ASSERT_IMPL(a_clear_closed, state == S_CLR, !in_ch.ready, "input open during clearing")

endmodule

/* bench/psg_tone_noise_envelope_synth_tb.sv */
//------------------------------------------------------------------------------
// psg_tone_noise_envelope_synth_tb
// Self-checking bench for the sound generator bank: register writes and sample
// ticks go in on a valid/ready channel; a local model predicts each sample.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_tone_noise_envelope_synth_tb;
  import psg_pkg::*;

  localparam int NChips = 3;
  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  psg_if #(.payload_t(psg_in_t))  in_ch ();
  psg_if #(.payload_t(psg_out_t)) out_ch ();

  psg_tone_noise_envelope_synth dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state of the chip bank.
  logic [7:0]  sreg [NChips][16];
  logic [12:0] pcnt [NChips][4];
  logic        tneg [NChips][3];
  logic [16:0] lfsr [NChips];
  logic [20:0] ecnt [NChips];
  logic [4:0]  estep [NChips];
  logic        erise [NChips];
  logic        ehold [NChips];
  logic [3:0]  eshape [NChips];
  logic        lvalid [NChips];
  logic [3:0]  slatch [NChips];
  logic [3:0]  elevel [NChips];
  logic [1:0]  m_chips;
  logic [3:0]  m_inc;
  logic [3:0]  m_gain;
  logic [7:0]  m_div;

  logic [15:0] expected_samples [$];
  int errors = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int writes_sent = 0;
  int samples_seen = 0;
  int cycles = 0;
  bit busy_burst = 1'b0;

  task automatic model_reset();
    for (int k = 0; k < NChips; k++) begin
      for (int i = 0; i < 16; i++) sreg[k][i] = '0;
      for (int i = 0; i < 4; i++) pcnt[k][i] = '0;
      for (int i = 0; i < 3; i++) tneg[k][i] = 1'b0;
      lfsr[k] = 17'd1;
      ecnt[k] = '0; estep[k] = '0; erise[k] = 1'b0; ehold[k] = 1'b0;
      eshape[k] = '0; lvalid[k] = 1'b0; slatch[k] = '0; elevel[k] = '0;
    end
    m_chips = 2'd1; m_inc = 4'd9; m_gain = 4'd11; m_div = 8'd1;
  endtask

  // Envelope generator for one chip.
  task automatic advance_envelope(int k);
    logic [15:0] per;
    logic [20:0] full;
    per = {sreg[k][12], sreg[k][11]};
    if (!ehold[k]) begin
      full = (per != 16'd0) ? {1'b0, per, 4'b0} : 21'd16;
      ecnt[k] = ecnt[k] + {17'd0, m_inc};
      if (ecnt[k] >= full) begin
        ecnt[k] = ecnt[k] - full;
        estep[k] = estep[k] + 5'd1;
        if (estep[k] >= 5'd16) begin
          if (!eshape[k][3]) begin
            estep[k] = 5'd0; ehold[k] = 1'b1; erise[k] = 1'b0;
          end else if (eshape[k][0]) begin
            estep[k] = 5'd15; ehold[k] = 1'b1;
            if (eshape[k][1]) erise[k] = !erise[k];
          end else begin
            estep[k] = 5'd0;
            if (eshape[k][1]) erise[k] = !erise[k];
          end
        end
      end
    end
    if (ehold[k] && !eshape[k][3]) elevel[k] = 4'd0;
    else elevel[k] = erise[k] ? estep[k][3:0] : 4'd15 - estep[k][3:0];
  endtask

  // One chip's contribution to the mix for a tick.
  task automatic advance_chip(int k, inout logic [15:0] acc);
    logic [4:0]  nper;
    logic [11:0] per;
    logic [1:0]  en;
    logic [3:0]  vol;
    logic        high;
    logic [15:0] amount;
    nper = sreg[k][6][4:0];
    if (nper != 5'd0) begin
      pcnt[k][3] = pcnt[k][3] + {9'd0, m_inc};
      if (pcnt[k][3] > {8'd0, nper}) begin
        pcnt[k][3] = pcnt[k][3] - {8'd0, nper};
        lfsr[k] = {lfsr[k][0] ^ lfsr[k][3], lfsr[k][16:1]};
      end
    end
    advance_envelope(k);
    for (int c = 0; c < 3; c++) begin
      per = {sreg[k][2*c+1][3:0], sreg[k][2*c]};
      en = ~{sreg[k][7][c+3], sreg[k][7][c]};
      vol = sreg[k][8+c][4] ? elevel[k] : sreg[k][8+c][3:0];
      if (per != 12'd0 && vol != 4'd0 && en != 2'b00) begin
        high = 1'b1;
        amount = {12'd0, m_gain} * {12'd0, vol};
        if (en[0] && tneg[k][c]) high = 1'b0;
        if (en[1] && !lfsr[k][0]) high = 1'b0;
        acc = high ? acc + amount : acc - amount;
        pcnt[k][c] = pcnt[k][c] + {9'd0, m_inc};
        if (pcnt[k][c] > {1'b0, per}) begin
          pcnt[k][c] = pcnt[k][c] - {1'b0, per};
          tneg[k][c] = !tneg[k][c];
        end
      end
    end
  endtask

  // Applies one accepted beat to the model; a tick queues its sample.
  task automatic predict_sample(psg_in_t it);
    logic [15:0] acc;
    int n;
    int sv;
    int dv;
    if (it.op == OpWrite) begin
      if (it.chip < NChips) begin
        sreg[it.chip][it.reg_addr] = it.reg_data;
        if (it.reg_addr == RegShape &&
            (!lvalid[it.chip] || it.reg_data[3:0] != slatch[it.chip])) begin
          lvalid[it.chip] = 1'b1; slatch[it.chip] = it.reg_data[3:0];
          eshape[it.chip] = it.reg_data[3:0]; estep[it.chip] = 5'd0;
          ecnt[it.chip] = 21'd0; ehold[it.chip] = 1'b0;
          erise[it.chip] = it.reg_data[2];
        end
      end
    end else begin
      acc = '0;
      n = (m_chips > NChips) ? NChips : int'(m_chips);
      for (int k = 0; k < n; k++) advance_chip(k, acc);
      acc = acc << 6;
      sv = int'($signed(acc));
      dv = (m_div == 8'd0) ? 1 : int'(m_div);
      sv = sv / dv;
      expected_samples.push_back(sv[15:0]);
    end
  endtask

  // Drive one beat; the model is updated when the beat is accepted.
  task automatic send_beat(logic op, logic [1:0] chip, logic [3:0] ra, logic [7:0] rd);
    psg_in_t it;
    it = '{op: op, chip: chip, reg_addr: ra, reg_data: rd};
    if (!busy_burst && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    busy_burst = ($urandom_range(0, 9) != 0);
    in_ch.valid = 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(it);
    if (op == OpTick) ticks_sent++; else writes_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(int chip, int ra, int rd);
    send_beat(OpWrite, chip[1:0], ra[3:0], rd[7:0]);
  endtask

  task automatic tick();
    send_beat(OpTick, 2'd0, 4'd0, 8'd0);
  endtask

  // Waits for all samples to drain, then sets one configuration register.
  task automatic set_config(logic [1:0] idx, logic [7:0] val);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgChips: m_chips = val[1:0];
      CfgInc:   m_inc = val[3:0];
      CfgGain:  m_gain = val[3:0];
      default:  m_div = val;
    endcase
  endtask

  // Receiver stall pattern: long open stretches and bursts of stalls.
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if ((cycles / 300) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // Sample checker.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      samples_seen <= samples_seen + 1;
      if (expected_samples.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected sample %h", out_ch.data.sample);
        mismatches++;
      end else begin
        if (out_ch.data.sample !== expected_samples[0]) begin
          errors++;
          if (mismatches < 10)
            $display("sample mismatch: expected %h got %h",
                     expected_samples[0], out_ch.data.sample);
          mismatches++;
        end
        void'(expected_samples.pop_front());
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("psg_tone_noise_envelope_synth_tb NOT OK");
      $finish;
    end
  end

  // Field extremes, beats to an absent chip and simple tones on chip 0.
  task automatic test_directed();
    write_reg(0, 0, 8'h01); write_reg(0, 1, 8'h00);
    write_reg(0, 7, 8'hFE); write_reg(0, 8, 8'h0F);
    repeat (3) tick();
    write_reg(0, 2, 8'hFF); write_reg(0, 3, 8'hFF);
    write_reg(0, 9, 8'h1F);
    write_reg(0, 13, 8'h0E); write_reg(0, 13, 8'h0E);
    write_reg(3, 8, 8'hAA);
    send_beat(OpTick, 2'd3, 4'hF, 8'hFF);
    write_reg(0, 6, 8'h01); write_reg(0, 7, 8'h00);
    write_reg(0, 10, 8'h08); write_reg(0, 4, 8'h00);
    write_reg(0, 11, 8'h00); write_reg(0, 12, 8'h00);
    repeat (6) tick();
  endtask

  // Envelope shapes run through full cycles with a short period.
  task automatic test_envelopes();
    set_config(CfgInc, 8'd15);
    for (int s = 0; s < 16; s++) begin
      write_reg(0, 13, s);
      repeat (40) tick();
    end
  endtask

  // Random register programs and ticks across settings, with some raw random beats.
  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        set_config(CfgChips, 8'($urandom_range(0, 3)));
        set_config(CfgInc, 8'($urandom_range(0, 15)));
        set_config(CfgGain, 8'($urandom_range(0, 15)));
        set_config(CfgDiv, 8'((i % 500 == 0) ? $urandom_range(0, 1) * 255
                                             : $urandom_range(0, 255)));
      end
      r = $urandom_range(0, 9);
      if (r < 6) tick();
      else if (r < 9) begin
        // Small periods keep tones and envelopes moving.
        int ra;
        ra = $urandom_range(0, 15);
        if (ra < 6 || ra == 11) write_reg($urandom_range(0, 2), ra,
                                          $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                               : $urandom_range(0, 255));
        else if (ra == 12) write_reg($urandom_range(0, 2), ra, $urandom_range(0, 3) == 0 ?
                                     $urandom_range(0, 255) : 0);
        else write_reg($urandom_range(0, 2), ra, $urandom_range(0, 255));
      end else send_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_envelopes();
    set_config(CfgChips, 8'd3);
    test_random(700);
    set_config(CfgChips, 8'd1);
    set_config(CfgDiv, 8'd255);
    test_random(100);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d writes and %0d ticks; %0d samples checked, %0d mismatches.",
             writes_sent, ticks_sent, samples_seen, mismatches);
    if (errors == 0) $display("psg_tone_noise_envelope_synth_tb OK");
    else $display("psg_tone_noise_envelope_synth_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/psg_pkg.sv
rtl/psg_if.sv
rtl/psg_tone_noise_envelope_synth.sv
bench/psg_tone_noise_envelope_synth_tb.sv
